[hdl/sha1mh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1mh_pkg
// Constants and types shared by the SHA-1 message hasher.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

    localparam int WordWidth   = 32;
    localparam int ByteWidth   = 8;
    localparam int WindowDepth = 16;
    localparam int HashWords   = 5;
    localparam int LengthWidth = 64;
    localparam int RoundCount  = 80;

    localparam logic [WordWidth-1:0] K_ROUND_0 = 32'h5a827999;
    localparam logic [WordWidth-1:0] K_ROUND_1 = 32'h6ed9eba1;
    localparam logic [WordWidth-1:0] K_ROUND_2 = 32'h8f1bbcdc;
    localparam logic [WordWidth-1:0] K_ROUND_3 = 32'hca62c1d6;

    localparam logic [0:HashWords-1][WordWidth-1:0] H_INIT = {
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [ByteWidth-1:0] PAD_ONE_BYTE  = 8'h80;
    localparam logic [ByteWidth-1:0] PAD_ZERO_BYTE = 8'h00;
    localparam logic [5:0]           LEN_FIELD_POS = 6'd56;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ROUND = 5'b00010,
        ST_FINAL = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_OUT   = 5'b10000
    } sha1mh_state_t;

    typedef logic [0:WindowDepth-1][WordWidth-1:0] window_t;
    typedef logic [0:HashWords-1][WordWidth-1:0]   hash_t;

endpackage

[hdl/sha1_message_hasher_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_hasher_unit
// Streaming SHA-1 engine: message bytes in, five digest words out per message.
// ----------------------------------------------------------------------------
// One message byte beat is taken per cycle while s_tready is high. Each time 64
// bytes are held, the block is compressed by one round unit in 80 rounds, one
// round per cycle, and the result is then folded into the hash in ST_FINAL;
// s_tready is low throughout. At end of message the 9 to 72 pad and length
// bytes go into the block one per cycle, apart from the compression between
// them when padding spills into a second block (one or two compressions), then
// the five digest words leave as five beats, H0 first, tlast on H4.
// ----------------------------------------------------------------------------
module sha1_message_hasher_unit
    import sha1mh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] message_byte
    input  logic        s_tlast,   // end_of_message
    input  logic [0:0]  s_tuser,   // [0] has_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic        m_tlast    // last_word
);

    sha1mh_state_t state_reg, state_next;

    window_t                 win_reg, win_next;
    hash_t                   hash_reg, hash_next;
    logic [WordWidth-1:0]    a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [WordWidth-1:0]    a_next, b_next, c_next, d_next, e_next;
    logic [LengthWidth-1:0]  bitlen_reg, bitlen_next;
    logic [5:0]              fill_reg, fill_next;
    logic [6:0]              round_reg, round_next;
    logic [2:0]              out_idx_reg, out_idx_next;
    logic                    pad_mode_reg, pad_mode_next;
    logic                    pad_one_reg, pad_one_next;
    logic                    len_phase_reg, len_phase_next;
    logic                    pad_done_reg, pad_done_next;

    logic                    s_beat, m_beat;
    logic [ByteWidth-1:0]    pad_byte;
    logic                    pad_in_len;
    logic [WordWidth-1:0]    w_mix, w_cur, f_val, k_val, t_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_beat   = m_tvalid && m_tready;
    assign m_tdata  = hash_reg[out_idx_reg];
    assign m_tlast  = (out_idx_reg == 3'(HashWords - 1));

    // round unit
    always_comb begin
        w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        w_cur = (round_reg < 7'd16) ? win_reg[0] : {w_mix[30:0], w_mix[31]};
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) ^ (~b_reg & d_reg);
            k_val = K_ROUND_0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND_1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) ^ (b_reg & d_reg) ^ (c_reg & d_reg);
            k_val = K_ROUND_2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND_3;
        end
        t_sum = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;
    end

    // pad byte source
    assign pad_in_len = !pad_one_reg && (len_phase_reg || fill_reg == LEN_FIELD_POS);
    always_comb begin
        if (pad_one_reg) begin
            pad_byte = PAD_ONE_BYTE;
        end else if (pad_in_len) begin
            pad_byte = bitlen_reg[LengthWidth-1 -: ByteWidth];
        end else begin
            pad_byte = PAD_ZERO_BYTE;
        end
    end

    always_comb begin
        state_next     = state_reg;
        win_next       = win_reg;
        hash_next      = hash_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        e_next         = e_reg;
        bitlen_next    = bitlen_reg;
        fill_next      = fill_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        pad_mode_next  = pad_mode_reg;
        pad_one_next   = pad_one_reg;
        len_phase_next = len_phase_reg;
        pad_done_next  = pad_done_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    if (s_tuser[0]) begin
                        win_next    = {win_reg[0][23:0], win_reg[1:WindowDepth-1], s_tdata};
                        fill_next   = fill_reg + 6'd1;
                        bitlen_next = bitlen_reg + 64'd8;
                    end
                    if (s_tlast) begin
                        pad_mode_next = 1'b1;
                        pad_one_next  = 1'b1;
                    end
                    if (s_tuser[0] && fill_reg == 6'd63) begin
                        state_next = ST_ROUND;
                        round_next = '0;
                        {a_next, b_next, c_next, d_next, e_next} = hash_reg;
                    end else if (s_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                win_next     = {win_reg[0][23:0], win_reg[1:WindowDepth-1], pad_byte};
                fill_next    = fill_reg + 6'd1;
                pad_one_next = 1'b0;
                if (pad_in_len) begin
                    bitlen_next    = {bitlen_reg[LengthWidth-ByteWidth-1:0], PAD_ZERO_BYTE};
                    len_phase_next = 1'b1;
                end
                if (fill_reg == 6'd63) begin
                    pad_done_next = pad_in_len;
                    state_next    = ST_ROUND;
                    round_next    = '0;
                    {a_next, b_next, c_next, d_next, e_next} = hash_reg;
                end
            end
            ST_ROUND: begin
                win_next   = {win_reg[1:WindowDepth-1], w_cur};
                e_next     = d_reg;
                d_next     = c_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                b_next     = a_reg;
                a_next     = t_sum;
                round_next = round_reg + 7'd1;
                if (round_reg == 7'(RoundCount - 1)) begin
                    state_next = ST_FINAL;
                    round_next = '0;
                end
            end
            ST_FINAL: begin
                hash_next[0] = hash_reg[0] + a_reg;
                hash_next[1] = hash_reg[1] + b_reg;
                hash_next[2] = hash_reg[2] + c_reg;
                hash_next[3] = hash_reg[3] + d_reg;
                hash_next[4] = hash_reg[4] + e_reg;
                if (pad_done_reg) begin
                    state_next   = ST_OUT;
                    out_idx_next = '0;
                end else if (pad_mode_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_beat) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (m_tlast) begin
                        state_next     = ST_IDLE;
                        hash_next      = H_INIT;
                        bitlen_next    = '0;
                        fill_next      = '0;
                        out_idx_next   = '0;
                        pad_mode_next  = 1'b0;
                        pad_one_next   = 1'b0;
                        len_phase_next = 1'b0;
                        pad_done_next  = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hash_reg      <= H_INIT;
            bitlen_reg    <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            pad_mode_reg  <= 1'b0;
            pad_one_reg   <= 1'b0;
            len_phase_reg <= 1'b0;
            pad_done_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            bitlen_reg    <= bitlen_next;
            fill_reg      <= fill_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            pad_mode_reg  <= pad_mode_next;
            pad_one_reg   <= pad_one_next;
            len_phase_reg <= len_phase_next;
            pad_done_reg  <= pad_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open at once");

    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND) |-> (round_reg < 7'(RoundCount)))
        else $error("round counter out of range");

    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 7'(RoundCount - 1)) |=> (state_reg == ST_FINAL))
        else $error("compression did not finish after last round");

    a_digest_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_beat && m_tlast) |=> (s_tready && fill_reg == 6'd0 && bitlen_reg == '0))
        else $error("engine not rearmed after digest");

    a_out_block_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (fill_reg == 6'd0 && pad_done_reg))
        else $error("digest sent before padding completed");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks sha1_message_hasher_unit against an in-bench SHA-1 digest predictor.
// Message bytes go in as stream beats with random gaps, idle beats and
// ignored bytes. Each digest beat is compared with the oldest predicted word.
// The run covers the empty message, padding that spills into a second block,
// and a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module testbench
    import sha1mh_pkg::*;
();

    typedef struct packed {
        logic [WordWidth-1:0] word;
        logic                 last;
    } digest_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    digest_beat_t digest_q[$];
    int           fail_count = 0;
    int           msg_items  = 0;
    bit           src_gaps   = 1'b1;
    bit           sink_gaps  = 1'b1;
    bit           hold_req   = 1'b0;

    // predictor state
    logic [WordWidth-1:0]   hash_st [HashWords];
    logic [WordWidth-1:0]   block_w [WindowDepth];
    logic [LengthWidth-1:0] len_bits;
    logic [5:0]             fill_cnt;

    sha1_message_hasher_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < HashWords; i++) hash_st[i] = H_INIT[i];
        for (int i = 0; i < WindowDepth; i++) block_w[i] = '0;
        len_bits = '0;
        fill_cnt = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] a, b, c, d, e, f, k, w, tmp;
        a = hash_st[0];
        b = hash_st[1];
        c = hash_st[2];
        d = hash_st[3];
        e = hash_st[4];
        for (int t = 0; t < RoundCount; t++) begin
            if (t < 16) begin
                w = block_w[t];
            end else begin
                w = rotl(block_w[(t - 3) & 15] ^ block_w[(t - 8) & 15]
                         ^ block_w[(t - 14) & 15] ^ block_w[t & 15], 1);
                block_w[t & 15] = w;
            end
            if (t < 20) begin
                f = (b & c) ^ (~b & d);
                k = K_ROUND_0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = K_ROUND_1;
            end else if (t < 60) begin
                f = (b & c) ^ (b & d) ^ (c & d);
                k = K_ROUND_2;
            end else begin
                f = b ^ c ^ d;
                k = K_ROUND_3;
            end
            tmp = rotl(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = tmp;
        end
        hash_st[0] += a;
        hash_st[1] += b;
        hash_st[2] += c;
        hash_st[3] += d;
        hash_st[4] += e;
    endfunction

    function automatic void absorb_byte(input logic [7:0] byte_val);
        block_w[fill_cnt[5:2]][8 * (3 - fill_cnt[1:0]) +: 8] = byte_val;
        fill_cnt = fill_cnt + 6'd1;
        if (fill_cnt == 6'd0) sha_compress();
    endfunction

    function automatic void predict_digest(input logic [7:0] byte_val, input logic has,
                                           input logic eom);
        logic [LengthWidth-1:0] len;
        digest_beat_t           beat;
        if (has) begin
            len_bits = len_bits + 64'd8;
            absorb_byte(byte_val);
        end
        if (eom) begin
            len = len_bits;
            absorb_byte(PAD_ONE_BYTE);
            while (fill_cnt != LEN_FIELD_POS) absorb_byte(PAD_ZERO_BYTE);
            for (int i = 0; i < 8; i++) absorb_byte(len[56 - 8 * i +: 8]);
            for (int i = 0; i < HashWords; i++) begin
                beat.word = hash_st[i];
                beat.last = (i == HashWords - 1);
                digest_q.push_back(beat);
            end
            sha_restart();
        end
    endfunction

    // one input beat; returns once it has been taken
    task automatic send_beat(input logic [7:0] byte_val, input logic has, input logic eom);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= byte_val;
        s_tuser  <= has;
        s_tlast  <= eom;
        do @(posedge aclk); while (!s_tready);
        predict_digest(byte_val, has, eom);
        if (has || eom) msg_items++;
    endtask

    task automatic send_message(input int nbytes, input bit end_on_byte, input int noise_pct);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1, (i == nbytes - 1) && end_on_byte);
        end
        if (nbytes == 0 || !end_on_byte) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // checker and output-side flow control
    initial begin : digest_sink
        int           stall_left;
        int           hold_left;
        digest_beat_t want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (digest_q.size() == 0) begin
                    fail_count++;
                    $error("unexpected digest beat: m_tdata=%h m_tlast=%b", m_tdata, m_tlast);
                end else begin
                    want = digest_q.pop_front();
                    if (m_tdata !== want.word) begin
                        fail_count++;
                        $error("digest_word mismatch: expected %h, actual %h", want.word, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        fail_count++;
                        $error("last_word mismatch: expected %b, actual %b", want.last, m_tlast);
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 9);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_empty_message();
        send_beat(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7f, 1'b1, 1'b1);
    endtask

    // "abc" with idle beats and invalid bytes mixed in, closed by an empty final beat
    task automatic test_ignored_beats();
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'h62, 1'b0, 1'b0);
        send_beat(8'h62, 1'b1, 1'b0);
        send_beat(8'h63, 1'b1, 1'b0);
        send_beat(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_output_hold();
        src_gaps = 1'b0;
        hold_req = 1'b1;
        for (int m = 0; m < 3; m++) send_message(4, m[0], 0);
        src_gaps = 1'b1;
    endtask

    task automatic test_random_messages();
        int goal;
        int nbytes;
        goal = msg_items + 170;
        while (msg_items < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: nbytes = $urandom_range(0, 20);
                4, 5, 6:    nbytes = $urandom_range(52, 68);
                7, 8:       nbytes = $urandom_range(20, 52);
                default:    nbytes = $urandom_range(100, 130);
            endcase
            src_gaps  = ($urandom_range(0, 2) != 0);
            sink_gaps = ($urandom_range(0, 2) != 0);
            send_message(nbytes, 1'($urandom_range(0, 1)), 10);
        end
    endtask

    task automatic test_back_to_back();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        send_message(55, 1'b1, 0);
        send_message(56, 1'b0, 0);
        send_message(64, 1'b1, 0);
    endtask

    initial begin
        int waited;
        sha_restart();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_message();
        test_byte_extremes();
        test_ignored_beats();
        test_output_hold();
        test_random_messages();
        test_back_to_back();
        s_tvalid <= 1'b0;

        waited = 0;
        while (digest_q.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);
        if (digest_q.size() != 0) begin
            fail_count++;
            $error("%0d digest beats never arrived", digest_q.size());
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sha1_message_hasher_unit.f]
hdl/sha1mh_pkg.sv
hdl/sha1_message_hasher_unit.sv
test/testbench.sv
